// ===== rtl/mrdf_pkg.sv =====
`default_nettype none

package mrdf_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int SCALE_BITS  = 16;

    // The voltage multiplier retires two sample bits a cycle, so an odd width is padded.
    localparam int MUL_BITS = SAMPLE_BITS + (SAMPLE_BITS % 2);
    localparam int VSTEPS   = MUL_BITS / 2;
    localparam int VPROD_W  = SCALE_BITS + MUL_BITS;
    localparam int VHI_W    = SCALE_BITS + 2;
    localparam int VSHIFT   = 10;
    localparam int VT_W     = VPROD_W - VSHIFT;

    localparam int DIFF_BITS = 8;
    localparam int GAIN_BITS = 9;
    localparam int CSTEPS    = DIFF_BITS / 2;
    localparam int CPROD_W   = GAIN_BITS + DIFF_BITS;
    localparam int CHI_W     = GAIN_BITS + 2;
    localparam int CSHIFT    = 8;
    localparam int CT_W      = CPROD_W - CSHIFT;

    localparam int CNT_W = $clog2(VSTEPS + 1);

    localparam int IN_TDATA_W  = ((2 * SAMPLE_BITS + 2 + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 32;

    localparam logic [1:0] ROW_BAT = 2'd0;
    localparam logic [1:0] ROW_OUT = 2'd1;
    localparam logic [1:0] ROW_CUR = 2'd2;

    localparam logic [1:0] MODE_OFF = 2'd0;
    localparam logic [1:0] MODE_LOW = 2'd1;
    localparam logic [1:0] MODE_MID = 2'd2;

    localparam logic [GAIN_BITS-1:0] GAIN_LOW  = 9'd155;
    localparam logic [GAIN_BITS-1:0] GAIN_MID  = 9'd233;
    localparam logic [GAIN_BITS-1:0] GAIN_HIGH = 9'd388;

    localparam logic [VT_W-1:0] OVER_V  = VT_W'(145);
    localparam logic [VT_W-1:0] UNDER_V = VT_W'(70);
    localparam logic [CT_W-1:0] OVER_I  = CT_W'(99);

    localparam logic [4:0] GLYPH_ZERO  = 5'd0;
    localparam logic [4:0] GLYPH_BLANK = 5'd16;
    localparam logic [4:0] GLYPH_POINT = 5'd19;
    localparam logic [4:0] GLYPH_U     = 5'd23;
    localparam logic [4:0] GLYPH_R     = 5'd26;
    localparam logic [4:0] GLYPH_V     = 5'd30;
    localparam logic [4:0] GLYPH_N     = 5'd31;

    localparam logic [2:0] ADDR_OUT_SCALE = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULV,
        ST_VFMT,
        ST_MULC,
        ST_CFMT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] value;
        logic [4:0] a;
        logic [4:0] b;
        logic [4:0] c;
        logic [4:0] d;
    } disp_row_t;

    typedef struct packed {
        logic [4:0] hund;
        logic [4:0] tens;
        logic [4:0] units;
    } digits_t;

    function automatic logic [GAIN_BITS-1:0] gain_of(input logic [1:0] mode);
        logic [GAIN_BITS-1:0] g;
        case (mode)
            MODE_LOW: g = GAIN_LOW;
            MODE_MID: g = GAIN_MID;
            default:  g = GAIN_HIGH;
        endcase
        return g;
    endfunction

    // Valid for values up to 199; tens come from a multiply by 205/2048.
    function automatic digits_t dec_digits(input logic [7:0] v);
        logic        h;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        digits_t     r;
        h     = (v >= 8'd100);
        rem   = h ? 7'(v - 8'd100) : v[6:0];
        prod  = 15'(rem) * 15'd205;
        tens  = prod[14:11];
        units = rem - 7'(7'(tens) * 7'd10);
        r.hund  = {4'b0, h};
        r.tens  = {1'b0, tens};
        r.units = {1'b0, units[3:0]};
        return r;
    endfunction

    function automatic disp_row_t format_voltage(input logic [VT_W-1:0] t);
        disp_row_t r;
        digits_t   dg;
        dg      = dec_digits(t[7:0]);
        r.value = t[7:0];
        if (t > OVER_V) begin
            r.a = GLYPH_ZERO;
            r.b = GLYPH_V;
            r.c = GLYPH_R;
            r.d = GLYPH_BLANK;
        end else if (t < UNDER_V) begin
            r.a = GLYPH_U;
            r.b = GLYPH_ZERO;
            r.c = GLYPH_N;
            r.d = GLYPH_BLANK;
        end else begin
            r.a = dg.hund;
            r.b = dg.tens;
            r.c = GLYPH_POINT;
            r.d = dg.units;
        end
        return r;
    endfunction

    function automatic disp_row_t format_current(input logic charging,
                                                 input logic [CT_W-1:0] t);
        disp_row_t r;
        digits_t   dg;
        dg = dec_digits(t[7:0]);
        if (!charging) begin
            r.value = 8'd0;
            r.a     = GLYPH_BLANK;
            r.b     = GLYPH_ZERO;
            r.c     = GLYPH_POINT;
            r.d     = GLYPH_ZERO;
        end else if (t > OVER_I) begin
            r.value = t[7:0];
            r.a     = GLYPH_ZERO;
            r.b     = GLYPH_V;
            r.c     = GLYPH_R;
            r.d     = GLYPH_BLANK;
        end else begin
            r.value = t[7:0];
            r.a     = GLYPH_BLANK;
            r.b     = dg.tens;
            r.c     = GLYPH_POINT;
            r.d     = dg.units;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/meter_reading_digit_formatter.sv =====
// Turns one battery sample, one output sample and a charge mode into three display rows
// (battery volts, output volts, charge current), each as a scaled value and four glyph
// codes, delivered in row order with tlast on the current row. Both voltage products are
// formed by shift-and-add units that take two sample bits a cycle, the current product by
// a third such unit over the eight-bit voltage difference, and formatting follows in a
// state of its own after the voltage products and again after the current product. A new
// item is taken only once the current row of the last item is in the output register;
// that row may still wait there while the next item is being worked on. The scale
// registers sit at byte addresses 0 and 4.
`default_nettype none

module meter_reading_digit_formatter (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // battery_sample, output_sample, charge_mode from bit 0 up; zero padded.
    input  logic [mrdf_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // scaled_value, glyph_a, glyph_b, glyph_c, glyph_d from bit 0 up; zero padded.
    output logic [mrdf_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // row
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import mrdf_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VPROD_W-1:0]    pbat_reg, pbat_next;
    logic [VPROD_W-1:0]    pout_reg, pout_next;
    logic [CPROD_W-1:0]    pcur_reg, pcur_next;
    logic [GAIN_BITS-1:0]  gain_reg, gain_next;
    logic [1:0]            mode_reg, mode_next;
    logic                  chg_reg, chg_next;
    disp_row_t             rows_reg [3];
    disp_row_t             rows_next [3];
    logic [1:0]            emit_reg, emit_next;
    logic                  m_valid_reg, m_valid_next;
    logic [1:0]            m_row_reg, m_row_next;
    disp_row_t             m_data_reg, m_data_next;
    logic [SCALE_BITS-1:0] bat_scale_reg, bat_scale_next;
    logic [SCALE_BITS-1:0] out_scale_reg, out_scale_next;

    logic                  in_fire;
    logic                  out_free;
    logic                  cfg_write;
    logic [SAMPLE_BITS-1:0] in_bat;
    logic [SAMPLE_BITS-1:0] in_out;
    logic [1:0]            in_mode;
    logic [VHI_W-1:0]      bat_hi;
    logic [VHI_W-1:0]      out_hi;
    logic [CHI_W-1:0]      cur_hi;
    logic [VT_W-1:0]       t_bat;
    logic [VT_W-1:0]       t_out;
    logic [7:0]            bat8;
    logic [7:0]            out8;
    logic                  charging;

    assign in_bat  = s_tdata[SAMPLE_BITS-1:0];
    assign in_out  = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign in_mode = s_tdata[2*SAMPLE_BITS+1:2*SAMPLE_BITS];

    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite;

    // Each step adds two multiplier bits times the multiplicand into the upper half and
    // shifts the whole product right, so the multiplier bits drain out of the low end.
    assign bat_hi = {2'b0, pbat_reg[VPROD_W-1:MUL_BITS]}
                  + VHI_W'(VHI_W'(pbat_reg[1:0]) * VHI_W'(bat_scale_reg));
    assign out_hi = {2'b0, pout_reg[VPROD_W-1:MUL_BITS]}
                  + VHI_W'(VHI_W'(pout_reg[1:0]) * VHI_W'(out_scale_reg));
    assign cur_hi = {2'b0, pcur_reg[CPROD_W-1:DIFF_BITS]}
                  + CHI_W'(CHI_W'(pcur_reg[1:0]) * CHI_W'(gain_reg));

    assign t_bat    = pbat_reg[VPROD_W-1:VSHIFT];
    assign t_out    = pout_reg[VPROD_W-1:VSHIFT];
    assign bat8     = t_bat[7:0];
    assign out8     = t_out[7:0];
    assign charging = (mode_reg != MODE_OFF) && (out8 >= bat8);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_MULV;
                end
            end
            ST_MULV: begin
                if (cnt_reg == CNT_W'(VSTEPS - 1)) begin
                    state_next = ST_VFMT;
                end
            end
            ST_VFMT: state_next = ST_MULC;
            ST_MULC: begin
                if (cnt_reg == CNT_W'(CSTEPS - 1)) begin
                    state_next = ST_CFMT;
                end
            end
            ST_CFMT: state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free && emit_reg == ROW_CUR) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready       = 1'b0;
        cnt_next       = cnt_reg;
        pbat_next      = pbat_reg;
        pout_next      = pout_reg;
        pcur_next      = pcur_reg;
        gain_next      = gain_reg;
        mode_next      = mode_reg;
        chg_next       = chg_reg;
        rows_next      = rows_reg;
        emit_next      = emit_reg;
        m_valid_next   = m_valid_reg;
        m_row_next     = m_row_reg;
        m_data_next    = m_data_reg;
        bat_scale_next = bat_scale_reg;
        out_scale_next = out_scale_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cnt_next  = '0;
                pbat_next = {{SCALE_BITS{1'b0}}, MUL_BITS'(in_bat)};
                pout_next = {{SCALE_BITS{1'b0}}, MUL_BITS'(in_out)};
                mode_next = in_mode;
                gain_next = gain_of(in_mode);
            end
            ST_MULV: begin
                cnt_next  = cnt_reg + 1'b1;
                pbat_next = {bat_hi, pbat_reg[MUL_BITS-1:2]};
                pout_next = {out_hi, pout_reg[MUL_BITS-1:2]};
            end
            ST_VFMT: begin
                cnt_next     = '0;
                rows_next[0] = format_voltage(t_bat);
                rows_next[1] = format_voltage(t_out);
                chg_next     = charging;
                pcur_next    = {{GAIN_BITS{1'b0}}, charging ? 8'(out8 - bat8) : 8'd0};
            end
            ST_MULC: begin
                cnt_next  = cnt_reg + 1'b1;
                pcur_next = {cur_hi, pcur_reg[DIFF_BITS-1:2]};
            end
            ST_CFMT: begin
                rows_next[2] = format_current(chg_reg, pcur_reg[CPROD_W-1:CSHIFT]);
                emit_next    = ROW_BAT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_row_next   = emit_reg;
                    m_data_next  = rows_reg[emit_reg];
                    emit_next    = emit_reg + 1'b1;
                end
            end
            default: ;
        endcase

        if (cfg_write) begin
            if (paddr[2]) begin
                out_scale_next = pwdata[SCALE_BITS-1:0];
            end else begin
                bat_scale_next = pwdata[SCALE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            bat_scale_reg <= SCALE_BITS'(1024);
            out_scale_reg <= SCALE_BITS'(1024);
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            bat_scale_reg <= bat_scale_next;
            out_scale_reg <= out_scale_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        pbat_reg   <= pbat_next;
        pout_reg   <= pout_next;
        pcur_reg   <= pcur_next;
        gain_reg   <= gain_next;
        mode_reg   <= mode_next;
        chg_reg    <= chg_next;
        rows_reg   <= rows_next;
        emit_reg   <= emit_next;
        m_row_reg  <= m_row_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_row_reg;
    assign m_tlast  = (m_row_reg == ROW_CUR);
    assign m_tdata  = OUT_TDATA_W'({m_data_reg.d, m_data_reg.c, m_data_reg.b,
                                    m_data_reg.a, m_data_reg.value});

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_OUT_SCALE) ? {16'b0, out_scale_reg}
                  : (paddr[2] ? {16'b0, out_scale_reg} : {16'b0, bat_scale_reg});

    a_row_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ROW_BAT || m_tuser == ROW_OUT || m_tuser == ROW_CUR))
        else $error("result row code out of range");

    a_point_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22:18] == GLYPH_POINT || m_tdata[22:18] == GLYPH_R
                      || m_tdata[22:18] == GLYPH_N))
        else $error("third glyph is not a point or pattern glyph");

    a_current_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ROW_CUR && m_tdata[12:8] == GLYPH_BLANK)
        |-> (m_tdata[22:18] == GLYPH_POINT && m_tdata[17:13] <= 5'd9
             && m_tdata[27:23] <= 5'd9))
        else $error("current row digits malformed");

    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser == ROW_BAT) |=> (m_tvalid && m_tuser == ROW_OUT))
        else $error("output row does not follow battery row");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire) |=> (!s_tready && state_reg == ST_MULV && cnt_reg == '0))
        else $error("accepted item did not start the voltage multiply");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrdf_pkg::*;

    localparam logic [2:0] ADDR_BAT_SCALE = 3'd0;
    localparam logic [1:0] MODE_HIGH      = 2'd3;

    localparam int VOLT_OVER_TENTHS  = 145;
    localparam int VOLT_UNDER_TENTHS = 70;
    localparam int AMPS_OVER         = 99;
    localparam int GAIN_MODE_LOW     = 155;
    localparam int GAIN_MODE_MID     = 233;
    localparam int GAIN_MODE_HIGH    = 388;

    localparam int IDLE_PAD       = 20;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [9:0] bat;
        logic [9:0] out;
        logic [1:0] mode;
    } reading_t;

    typedef struct {
        logic [1:0] row;
        logic [7:0] value;
        logic [4:0] ga;
        logic [4:0] gb;
        logic [4:0] gc;
        logic [4:0] gd;
        logic       last;
    } display_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [2:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    reading_t     pending_readings[$];
    display_row_t expected_rows[$];
    logic [15:0]  bat_scale_q = 16'd1024;
    logic [15:0]  out_scale_q = 16'd1024;
    bit           req_taken = 1'b0;
    int           mismatch_count = 0;
    int           idle_cycles = 0;

    meter_reading_digit_formatter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 aclk = ~aclk;

    function automatic display_row_t format_voltage_row(logic [1:0] row, logic [9:0] sample,
                                                        logic [15:0] scale);
        display_row_t r;
        logic [25:0]  prod;
        int unsigned  tenths;
        prod   = 26'(sample) * 26'(scale);
        tenths = 32'(prod[25:10]);
        r.row   = row;
        r.value = tenths[7:0];
        r.last  = 1'b0;
        if (tenths > VOLT_OVER_TENTHS) begin
            r.ga = GLYPH_ZERO;
            r.gb = GLYPH_V;
            r.gc = GLYPH_R;
            r.gd = GLYPH_BLANK;
        end else if (tenths < VOLT_UNDER_TENTHS) begin
            r.ga = GLYPH_U;
            r.gb = GLYPH_ZERO;
            r.gc = GLYPH_N;
            r.gd = GLYPH_BLANK;
        end else begin
            r.ga = 5'(tenths / 100);
            r.gb = 5'((tenths / 10) % 10);
            r.gc = GLYPH_POINT;
            r.gd = 5'(tenths % 10);
        end
        return r;
    endfunction

    // Only the low eight bits of each voltage take part in the current.
    function automatic display_row_t format_current_row(logic [7:0] bat8, logic [7:0] out8,
                                                        logic [1:0] mode);
        display_row_t r;
        int unsigned  gain;
        int unsigned  amps;
        r.row  = ROW_CUR;
        r.last = 1'b1;
        if (mode == MODE_OFF || out8 < bat8) begin
            r.value = 8'd0;
            r.ga    = GLYPH_BLANK;
            r.gb    = GLYPH_ZERO;
            r.gc    = GLYPH_POINT;
            r.gd    = GLYPH_ZERO;
        end else begin
            case (mode)
                MODE_LOW: gain = GAIN_MODE_LOW;
                MODE_MID: gain = GAIN_MODE_MID;
                default:  gain = GAIN_MODE_HIGH;
            endcase
            amps    = ((out8 - bat8) * gain) >> 8;
            r.value = amps[7:0];
            if (amps > AMPS_OVER) begin
                r.ga = GLYPH_ZERO;
                r.gb = GLYPH_V;
                r.gc = GLYPH_R;
                r.gd = GLYPH_BLANK;
            end else begin
                r.ga = GLYPH_BLANK;
                r.gb = 5'(amps / 10);
                r.gc = GLYPH_POINT;
                r.gd = 5'(amps % 10);
            end
        end
        return r;
    endfunction

    function automatic void predict_rows(logic [IN_TDATA_W-1:0] data);
        display_row_t bat_row;
        display_row_t out_row;
        bat_row = format_voltage_row(ROW_BAT, data[9:0], bat_scale_q);
        out_row = format_voltage_row(ROW_OUT, data[19:10], out_scale_q);
        expected_rows.push_back(bat_row);
        expected_rows.push_back(out_row);
        expected_rows.push_back(format_current_row(bat_row.value, out_row.value,
                                                   data[21:20]));
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Monitor: tracks register writes, predicts on each accepted request and checks rows.
    always @(posedge aclk) begin
        display_row_t want;
        if (!aresetn) begin
            req_taken = 1'b0;
        end else begin
            req_taken = s_tvalid && s_tready;
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_BAT_SCALE)
                    bat_scale_q = pwdata[15:0];
                else if (paddr == ADDR_OUT_SCALE)
                    out_scale_q = pwdata[15:0];
            end
            if (req_taken)
                predict_rows(s_tdata);
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    $error("row %0d arrived with nothing expected", m_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_rows.pop_front();
                    check_field("row", 32'(want.row), 32'(m_tuser));
                    check_field("scaled_value", 32'(want.value), 32'(m_tdata[7:0]));
                    check_field("glyph_a", 32'(want.ga), 32'(m_tdata[12:8]));
                    check_field("glyph_b", 32'(want.gb), 32'(m_tdata[17:13]));
                    check_field("glyph_c", 32'(want.gc), 32'(m_tdata[22:18]));
                    check_field("glyph_d", 32'(want.gd), 32'(m_tdata[27:23]));
                    check_field("last_row", 32'(want.last), 32'(m_tlast));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sender: bursts of requests separated by random gaps.
    int burst_left = 4;
    int gap_left   = 0;

    always @(negedge aclk) begin
        reading_t rd;
        logic     next_valid;
        next_valid = 1'b0;
        if (aresetn && !(s_tvalid && !req_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_readings.size() > 0) begin
                rd         = pending_readings.pop_front();
                next_valid = 1'b1;
                s_tdata   <= IN_TDATA_W'({rd.mode, rd.out, rd.bat});
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 10);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: switches among always ready, coin-flip and mostly stalled.
    int stall_style = 0;
    int stall_timer = 0;

    always @(negedge aclk) begin
        if (stall_timer == 0) begin
            stall_style = $urandom_range(0, 2);
            stall_timer = $urandom_range(20, 80);
        end else begin
            stall_timer--;
        end
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic add_reading(int unsigned bat, int unsigned out, logic [1:0] mode);
        reading_t rd;
        rd.bat  = bat[9:0];
        rd.out  = out[9:0];
        rd.mode = mode;
        pending_readings.push_back(rd);
    endtask

    // Mostly output near battery so the charge current stays in its digit range.
    task automatic add_random_readings(int count);
        int unsigned bat;
        int unsigned out;
        repeat (count) begin
            bat = $urandom_range(0, 1023);
            if ($urandom_range(0, 3) == 0)
                out = $urandom_range(0, 1023);
            else
                out = bat + $urandom_range(0, 80);
            if (out > 1023)
                out = 1023;
            add_reading(bat, out, 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic wait_idle();
        while (pending_readings.size() != 0 || s_tvalid || expected_rows.size() != 0)
            @(negedge aclk);
        repeat (IDLE_PAD) @(negedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(logic [15:0] bat_scale, logic [15:0] out_scale, int count);
        wait_idle();
        apb_write(ADDR_BAT_SCALE, {16'd0, bat_scale});
        apb_write(ADDR_OUT_SCALE, {16'd0, out_scale});
        add_random_readings(count);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // With unit scale the tenths equal the samples, so limits are hit directly.
        add_reading(0, 0, MODE_OFF);
        add_reading(1023, 1023, MODE_HIGH);
        add_reading(145, 146, MODE_LOW);
        add_reading(70, 69, MODE_MID);
        add_reading(146, 145, MODE_HIGH);
        add_reading(69, 70, MODE_OFF);
        add_reading(100, 100, MODE_LOW);
        add_reading(150, 100, MODE_MID);
        add_reading(0, 166, MODE_LOW);
        add_reading(0, 165, MODE_LOW);
        add_reading(0, 255, MODE_HIGH);
        add_reading(300, 44, MODE_LOW);
        add_reading(256, 255, MODE_MID);
        add_reading(0, 80, MODE_LOW);
        add_reading(99, 123, MODE_HIGH);
        add_reading(1023, 0, MODE_MID);
        add_reading(512, 768, MODE_LOW);
        add_reading(70, 145, MODE_OFF);
        add_reading(120, 139, MODE_MID);
        add_reading(199, 200, MODE_HIGH);
        add_random_readings(16);

        run_phase(16'hFFFF, 16'h0000, 12);
        run_phase(16'h0000, 16'hFFFF, 12);
        repeat (2)
            run_phase(16'($urandom_range(100, 260)), 16'($urandom_range(100, 260)), 12);
        run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 10);
        run_phase(16'd1024, 16'd1024, 10);

        while (pending_readings.size() != 0 || s_tvalid || expected_rows.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && expected_rows.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/mrdf_pkg.sv
rtl/meter_reading_digit_formatter.sv
test/tb_top.sv
